### rtl/core/wtc_pkg.sv
// Shared constants, types and helpers for the whitespace token capture block.
`timescale 1ns / 1ps
package wtc_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 7;
  localparam int TICK_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OPQ_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;

  localparam logic [LEN_W-1:0]  CAP_RESET     = 7'd64;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [LEN_W-1:0]  CAP_MAX       = LEN_W'(STORE_DEPTH);

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;

  // Work handed from the front to the back.
  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } op_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) ||
           (b == CH_TAB) || (b == CH_VT);
  endfunction

endpackage

### rtl/core/wtc_front.sv
// Front end: config registers, scan state machine and op generation.
`timescale 1ns / 1ps
module wtc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_cmd,
  input  logic [7:0]                    in_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          op_push,
  output wtc_pkg::op_t                  op,
  input  logic                          op_full
);
  import wtc_pkg::*;

  localparam logic [1:0] M_SKIP    = 2'd0;
  localparam logic [1:0] M_CAPTURE = 2'd1;
  localparam logic [1:0] M_FULL    = 2'd2;
  localparam logic [1:0] M_DROP    = 2'd3;

  logic [LEN_W-1:0]  capacity_r;
  logic [TICK_W-1:0] timeout_r;
  logic [1:0]        mode_r, mode_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt;
  logic              ended_r, ended_nxt;

  logic [LEN_W-1:0]  eff_cap;
  logic [TICK_W-1:0] limit;
  logic [TICK_W-1:0] idle_inc;
  logic [LEN_W-1:0]  count_inc;
  logic              accept;
  logic              blank;

  assign cfg_ready = 1'b1;
  assign in_full   = op_full;
  assign accept    = in_push && !op_full;
  assign blank     = is_blank(in_byte);

  always_comb begin
    eff_cap = capacity_r;
    if (eff_cap == '0) eff_cap = LEN_W'(1);
    if (eff_cap > CAP_MAX) eff_cap = CAP_MAX;
  end

  assign limit     = (timeout_r == '0) ? TICK_W'(1) : timeout_r;
  assign idle_inc  = (idle_r == '1) ? idle_r : idle_r + TICK_W'(1);
  assign count_inc = count_r + LEN_W'(1);

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    idle_nxt  = idle_r;
    ended_nxt = ended_r;
    op_push   = 1'b0;
    op.kind   = OP_STORE;
    op.data   = in_byte;
    op.addr   = count_r[ADDR_W-1:0];
    op.len    = count_r;
    if (accept) begin
      if (in_cmd == CMD_TICK) begin
        if (!ended_r) begin
          idle_nxt = idle_inc;
          if (idle_inc >= limit) begin
            ended_nxt = 1'b1;
            count_nxt = '0;
            mode_nxt  = M_SKIP;
            if (mode_r == M_CAPTURE || mode_r == M_FULL) begin
              op_push = 1'b1;
              op.kind = OP_EMIT;
            end
          end
        end
      end else begin
        idle_nxt  = '0;
        ended_nxt = 1'b0;
        unique case (mode_r)
          M_SKIP: begin
            if (!blank) begin
              op_push   = 1'b1;
              op.addr   = '0;
              count_nxt = LEN_W'(1);
              mode_nxt  = (LEN_W'(1) >= eff_cap) ? M_FULL : M_CAPTURE;
            end
          end
          M_CAPTURE: begin
            if (blank) begin
              op_push   = 1'b1;
              op.kind   = OP_EMIT;
              count_nxt = '0;
              mode_nxt  = M_SKIP;
            end else if (count_r >= eff_cap) begin
              count_nxt = '0;
              mode_nxt  = M_DROP;
            end else begin
              op_push   = 1'b1;
              count_nxt = count_inc;
              mode_nxt  = (count_inc >= eff_cap) ? M_FULL : M_CAPTURE;
            end
          end
          M_FULL: begin
            count_nxt = '0;
            if (blank) begin
              op_push  = 1'b1;
              op.kind  = OP_EMIT;
              mode_nxt = M_SKIP;
            end else begin
              mode_nxt = M_DROP;
            end
          end
          M_DROP: begin
            if (blank) begin
              count_nxt = '0;
              mode_nxt  = M_SKIP;
            end
          end
          default: mode_nxt = M_SKIP;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      timeout_r  <= TIMEOUT_RESET;
      mode_r     <= M_SKIP;
      count_r    <= '0;
      idle_r     <= '0;
      ended_r    <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      idle_r  <= idle_nxt;
      ended_r <= ended_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CAPACITY) capacity_r <= cfg_data[LEN_W-1:0];
        else if (cfg_index == CFG_TIMEOUT) timeout_r <= cfg_data[TICK_W-1:0];
      end
    end
  end

endmodule

### rtl/core/wtc_op_fifo.sv
// Short op queue between the front and the back.
`timescale 1ns / 1ps
module wtc_op_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  wtc_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output wtc_pkg::op_t pop_op,
  output logic         valid
);
  import wtc_pkg::*;

  localparam int PTR_W = $clog2(OPQ_DEPTH);
  localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

  op_t              slots_r [OPQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(OPQ_DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_op  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

### rtl/core/wtc_back.sv
// Back end: token store, emit sequencer and output register.
`timescale 1ns / 1ps
module wtc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      op_valid,
  input  wtc_pkg::op_t              op,
  output logic                      op_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [7:0]                out_byte,
  output logic [wtc_pkg::LEN_W-1:0] out_token_length,
  output logic                      out_last
);
  import wtc_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_LOAD = 2'd2;

  logic [7:0]       store_r [STORE_DEPTH];
  logic [7:0]       rd_data_r;
  logic [1:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_last_r;
  logic             load;
  logic             last_k;
  logic             do_write;

  assign out_empty        = !out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_token_length = out_len_r;
  assign out_last         = out_last_r;

  assign last_k = (k_r + LEN_W'(1) == len_r);
  // Output slot frees up in the same cycle it is popped.
  assign load   = (state_r == B_LOAD) && (!out_valid_r || out_pop);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    op_pop        = 1'b0;
    do_write      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          if (op.kind == OP_STORE) begin
            do_write = 1'b1;
          end else if (op.len != '0) begin
            len_nxt   = op.len;
            k_nxt     = '0;
            state_nxt = B_READ;
          end
        end
      end
      B_READ: state_nxt = B_LOAD;
      B_LOAD: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          k_nxt         = k_r + LEN_W'(1);
          state_nxt     = last_k ? B_IDLE : B_READ;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) store_r[op.addr] <= op.data;
    rd_data_r <= store_r[k_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= rd_data_r;
      out_len_r  <= len_r;
      out_last_r <= last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      len_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/whitespace_token_capture.sv
// Top level of the whitespace-delimited token capture block.
`timescale 1ns / 1ps
// Serial bytes (in_cmd = 0) and millisecond ticks (in_cmd = 1) are pushed in
// one per transaction; white space is skipped and each token that fits the
// capacity is emitted byte by byte on the result side once a blank or an idle
// timeout ends it, with its length on every byte and a last flag on the final
// byte. The front takes one transaction per cycle while the op queue is not
// full, and hands store writes and emit requests to a two-entry op queue;
// in_full follows that queue. The back walks the 64-byte token store with a
// registered store read and then an output load per emitted byte, the load
// waiting while the output register is full. Configuration: cfg_index 0 is
// capacity, 1 is timeout_ticks; cfg_ready is always high.
module whitespace_token_capture (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_cmd,
  input  logic [7:0]                     in_byte,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_byte,
  output logic [wtc_pkg::LEN_W-1:0]      out_token_length,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wtc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wtc_pkg::*;

  op_t  f_op, b_op;
  logic f_push, q_full, q_valid, b_pop;

  wtc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_cmd    (in_cmd),
    .in_byte   (in_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_push   (f_push),
    .op        (f_op),
    .op_full   (q_full)
  );

  wtc_op_fifo u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .push_op (f_op),
    .full    (q_full),
    .pop     (b_pop),
    .pop_op  (b_op),
    .valid   (q_valid)
  );

  wtc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid         (q_valid),
    .op               (b_op),
    .op_pop           (b_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_token_length (out_token_length),
    .out_last         (out_last)
  );

endmodule

### tb/token_capture_checker.sv
// Checker for whitespace_token_capture: token predictor plus result scoreboard.
`timescale 1ns / 1ps
module token_capture_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_full,
  input  logic                           in_cmd,
  input  logic [7:0]                     in_byte,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  logic [7:0]                     out_byte,
  input  logic [wtc_pkg::LEN_W-1:0]      out_token_length,
  input  logic                           out_last,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [wtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wtc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import wtc_pkg::*;

  typedef enum logic [1:0] {
    SCAN_SKIP, SCAN_CAPTURE, SCAN_FULL, SCAN_DROP
  } scan_mode_t;

  typedef struct packed {
    logic [7:0]       ch;
    logic [LEN_W-1:0] len;
    logic             last;
  } token_char_t;

  logic [LEN_W-1:0]  cap_reg;
  logic [TICK_W-1:0] timeout_reg;
  scan_mode_t        mode;
  logic [LEN_W-1:0]  held_count;
  logic [TICK_W-1:0] idle_count;
  logic              stream_done;
  logic [7:0]        chars [STORE_DEPTH];
  token_char_t       expected_chars [$];

  task automatic report(input string msg);
    if (fail_count < 40) $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic white_char(input logic [7:0] b);
    return b inside {CH_SPACE, CH_LF, CH_CR, CH_TAB, CH_VT};
  endfunction

  function automatic logic [LEN_W-1:0] usable_capacity();
    logic [LEN_W-1:0] c;
    c = cap_reg;
    if (c == 0) c = 1;
    else if (c > CAP_MAX) c = CAP_MAX;
    return c;
  endfunction

  task automatic flush_token();
    logic [LEN_W-1:0] n;
    token_char_t      t;
    n = held_count;
    for (int k = 0; k < n; k++) begin
      t.ch   = chars[k];
      t.len  = n;
      t.last = (k + 1 == n);
      expected_chars.push_back(t);
    end
    held_count = 0;
    mode       = SCAN_SKIP;
  endtask

  task automatic keep_char(input logic [7:0] b);
    if (held_count < CAP_MAX) begin
      chars[held_count] = b;
      held_count++;
    end
    mode = (held_count >= usable_capacity()) ? SCAN_FULL : SCAN_CAPTURE;
  endtask

  task automatic advance_scanner(input logic cmd, input logic [7:0] b);
    logic [TICK_W-1:0] limit;
    limit = (timeout_reg == 0) ? TICK_W'(1) : timeout_reg;
    if (cmd == CMD_TICK) begin
      if (stream_done) return;
      if (idle_count != '1) idle_count++;
      if (idle_count < limit) return;
      stream_done = 1'b1;
      if (mode == SCAN_CAPTURE || mode == SCAN_FULL) flush_token();
      else begin
        mode       = SCAN_SKIP;
        held_count = 0;
      end
      return;
    end
    idle_count  = 0;
    stream_done = 1'b0;
    case (mode)
      SCAN_SKIP: begin
        if (!white_char(b)) begin
          held_count = 0;
          keep_char(b);
        end
      end
      SCAN_CAPTURE: begin
        if (white_char(b)) flush_token();
        else if (held_count >= usable_capacity()) begin
          mode       = SCAN_DROP;
          held_count = 0;
        end else keep_char(b);
      end
      SCAN_FULL: begin
        if (white_char(b)) flush_token();
        else begin
          mode       = SCAN_DROP;
          held_count = 0;
        end
      end
      default: begin
        if (white_char(b)) begin
          mode       = SCAN_SKIP;
          held_count = 0;
        end
      end
    endcase
  endtask

  task automatic check_char();
    token_char_t t;
    if (expected_chars.size() == 0) begin
      report($sformatf("unexpected result byte %02h len %0d last %0b",
                       out_byte, out_token_length, out_last));
      return;
    end
    t = expected_chars.pop_front();
    if (out_byte !== t.ch)
      report($sformatf("out_byte %02h, expected %02h", out_byte, t.ch));
    if (out_token_length !== t.len)
      report($sformatf("out_token_length %0d, expected %0d", out_token_length, t.len));
    if (out_last !== t.last)
      report($sformatf("out_last %0b, expected %0b (byte %02h)", out_last, t.last, t.ch));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cap_reg     = CAP_RESET;
      timeout_reg = TIMEOUT_RESET;
      mode        = SCAN_SKIP;
      held_count  = 0;
      idle_count  = 0;
      stream_done = 1'b0;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAPACITY: cap_reg     = cfg_data[LEN_W-1:0];
          CFG_TIMEOUT:  timeout_reg = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) advance_scanner(in_cmd, in_byte);
      if (out_pop && !out_empty) check_char();
    end
    pending = expected_chars.size();
  end

endmodule

### tb/tb.sv
// Testbench top for whitespace_token_capture: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import wtc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_cmd;
  logic [7:0]            in_byte;
  logic                  out_empty;
  logic                  out_pop;
  logic [7:0]            out_byte;
  logic [LEN_W-1:0]      out_token_length;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  // stimulus-side copy of the configuration, for shaping tokens
  int   cap_now;
  int   timeout_now;
  int   sent;
  bit   gaps_on;
  int   hold_reqs;
  int   holds_done;

  whitespace_token_capture i_dut (
    .clk, .rst_n, .in_push, .in_full, .in_cmd, .in_byte,
    .out_empty, .out_pop, .out_byte, .out_token_length, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  token_capture_checker i_checker (
    .clk, .rst_n, .in_push, .in_full, .in_cmd, .in_byte,
    .out_empty, .out_pop, .out_byte, .out_token_length, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stall bursts, plus long hold-offs on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    out_pop    = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left  = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Leaves in_push high after the transaction; settle() lowers it.
  task automatic push_item(input logic cmd, input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_cmd  <= cmd;
    in_byte <= b;
    do @(posedge clk); while (in_full);
    sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) push_item(CMD_BYTE, s[i]);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) push_item(CMD_TICK, 8'($urandom));
  endtask

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_LF;
      2:       return CH_CR;
      3:       return CH_TAB;
      default: return CH_VT;
    endcase
  endfunction

  function automatic logic [7:0] random_glyph();
    logic [7:0] b;
    do b = 8'($urandom); while (is_blank(b));
    return b;
  endfunction

  // lower push, wait out all expected results and any store work in flight
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CAPACITY) begin
      cap_now = val[LEN_W-1:0];
      if (cap_now == 0) cap_now = 1;
      if (cap_now > STORE_DEPTH) cap_now = STORE_DEPTH;
    end else begin
      timeout_now = (val == 0) ? 1 : val;
    end
  endtask

  // Mostly well-formed tokens with random content; some noise and broken runs.
  task automatic random_traffic(input int n);
    int stop;
    int sel;
    int len;
    stop = sent + n;
    while (sent < stop) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) push_item(1'($urandom), 8'($urandom));
      end else begin
        if ($urandom_range(0, 3) == 0) push_item(CMD_BYTE, random_blank());
        sel = $urandom_range(0, 19);
        if (sel < 10)      len = $urandom_range(1, (cap_now < 6) ? cap_now : 6);
        else if (sel < 15) len = $urandom_range(1, cap_now);
        else if (sel < 17) len = cap_now;
        else               len = cap_now + $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 15) == 0) push_item(CMD_TICK, 8'($urandom));
          push_item(CMD_BYTE, random_glyph());
        end
        if (timeout_now <= 8 && $urandom_range(0, 3) == 0)
          send_ticks(timeout_now + $urandom_range(0, 2));
        else
          push_item(CMD_BYTE, random_blank());
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_cmd      = CMD_BYTE;
    in_byte     = 8'h00;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_CAPACITY;
    cfg_data    = '0;
    cap_now     = CAP_RESET;
    timeout_now = TIMEOUT_RESET;
    sent        = 0;
    gaps_on     = 1'b1;
    hold_reqs   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // upper data bits must be ignored for capacity
    write_reg(CFG_CAPACITY, 16'hFF84);
    write_reg(CFG_TIMEOUT, 16'd2);
    push_item(CMD_BYTE, CH_SPACE);
    push_item(CMD_BYTE, CH_LF);
    push_item(CMD_BYTE, CH_CR);
    push_item(CMD_BYTE, CH_TAB);
    push_item(CMD_BYTE, CH_VT);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    send_text("A");
    push_item(CMD_BYTE, CH_TAB);
    send_text("BCDE");               // exactly at capacity, kept
    push_item(CMD_BYTE, CH_LF);
    send_text("FGHIJK");             // over capacity, dropped
    push_item(CMD_BYTE, CH_CR);
    send_ticks(3);                   // timeout with no token, then a repeat
    send_text("L");
    send_ticks(2);                   // timeout ends a token
    send_text("MNOP");
    send_ticks(2);                   // full token ended by timeout
    send_text("QRSTU");
    send_ticks(2);                   // timeout while dropping

    // capacity lowered under a partial token
    write_reg(CFG_CAPACITY, 16'd64);
    send_text("abcdef");
    write_reg(CFG_CAPACITY, 16'd3);
    push_item(CMD_BYTE, CH_VT);
    send_text("ghijk");
    write_reg(CFG_CAPACITY, 16'd2);
    send_text("l");
    push_item(CMD_BYTE, CH_SPACE);

    write_reg(CFG_CAPACITY, 16'd0);
    send_text("x yz ");
    write_reg(CFG_TIMEOUT, 16'd0);
    send_text("q");
    send_ticks(2);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    send_text("r");
    send_ticks(3);
    push_item(CMD_BYTE, CH_SPACE);

    write_reg(CFG_CAPACITY, 16'h007F);
    random_traffic(70);

    write_reg(CFG_CAPACITY, 16'd8);
    write_reg(CFG_TIMEOUT, 16'd3);
    random_traffic(40);
    hold_reqs++;                     // block must fill up and push back
    random_traffic(60);
    random_traffic(30);

    write_reg(CFG_CAPACITY, 16'd1);
    write_reg(CFG_TIMEOUT, 16'd1);
    random_traffic(50);

    write_reg(CFG_CAPACITY, 16'd100);
    write_reg(CFG_TIMEOUT, 16'd5);
    gaps_on = 1'b0;
    random_traffic(70);

    settle();
    repeat (30) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/core/wtc_pkg.sv
rtl/core/wtc_front.sv
rtl/core/wtc_op_fifo.sv
rtl/core/wtc_back.sv
rtl/core/whitespace_token_capture.sv
tb/token_capture_checker.sv
tb/tb.sv
